// ===== rtl/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg - shared definitions for the masked byte pattern scanner
// Register index codes, field widths and the pattern configuration bundle
// that the top level hands to the window compare logic.
// ----------------------------------------------------------------------------
package mbps_pkg;

   // field widths
   localparam int ADDR_W      = 64;
   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 6;
   localparam int OFFSET_W    = 32;
   localparam int CARE_W      = 32;
   localparam int PAT_WORD_W  = 64;
   localparam int PAT_WORDS   = 4;
   localparam int PAT_BYTES   = 32;

   // port widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 64;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PAT_0_7   = 3'd0,
      CSR_PAT_8_15  = 3'd1,
      CSR_PAT_16_23 = 3'd2,
      CSR_PAT_24_31 = 3'd3,
      CSR_CARE_MASK = 3'd4,
      CSR_LENGTH    = 3'd5,
      CSR_OFFSET    = 3'd6,
      CSR_BACKWARDS = 3'd7
   } csr_index_type;

   // pattern settings seen by the compare logic
   typedef struct packed {
      logic [PAT_BYTES*BYTE_W-1:0] pattern;   // byte i in bits 8i+7..8i
      logic [CARE_W-1:0]           care;
      logic [LEN_W-1:0]            length;
   } pattern_cfg_type;

endpackage

// ===== rtl/masked_byte_pattern_scanner.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner - masked byte signature search over a stream
// Scans an address range for a pattern with per-byte care bits and returns
// the first or last match, plus a signed offset, at the end of the range.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one memory byte per beat with its address; req_tlast marks the
//            final byte of a range. A byte can be taken every cycle unless req_tready is low.
//   rsp_*  : one beat per range: rsp_tuser is the found flag, rsp_tdata the
//            match start plus offset (zero when nothing was found).
//   csr_*  : pattern, care mask, length, offset and direction; write while
//            the block is idle.
//   Pipeline: input/window register, hit tracking register, result register.
//   The last byte of a range passes the window, hit tracking and result
//   registers before its result is on rsp_tvalid. Throughput is one byte per
//   cycle while req_tready is high, set by the window shift and parallel
//   masked compare. A stalled result port holds the result; bytes keep
//   flowing until a last byte waits in the window stage with the hit tracking
//   and result registers both full, then req_tready drops.
//   Reset (synchronous) clears the configuration and control registers and
//   empties the pipeline; data registers are loaded before they are used.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_we,
   input  logic [mbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mbps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // byte stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [mbps_pkg::REQ_DATA_W-1:0]   req_tdata,   // data_byte, byte_address
   input  logic                              req_tlast,   // last_byte
   // search result
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [mbps_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // match_address
   output logic [0:0]                        rsp_tuser    // found
);
   import mbps_pkg::*;

   localparam int WIN_W  = MAX_PATTERN_BYTES * BYTE_W;
   localparam int SEEN_W = $clog2(MAX_PATTERN_BYTES + 1);

   // configuration registers
   logic [PAT_WORD_W-1:0] pat_word_ff [PAT_WORDS];
   logic [CARE_W-1:0]     care_ff;
   logic [LEN_W-1:0]      length_ff;
   logic [OFFSET_W-1:0]   offset_ff;
   logic                  backwards_ff;

   // input / window stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0]     s1_addr_ff;
   logic                  s1_last_ff;
   logic [WIN_W-1:0]      window_ff, window_in;
   logic [SEEN_W-1:0]     seen_ff, seen_in;
   logic                  start_ff;     // next byte opens a new range

   // hit tracking
   logic                  hit_seen_ff, hit_seen_in;
   logic [ADDR_W-1:0]     hit_addr_ff, hit_addr_in;

   // finished range waiting for the result register
   logic                  fin_valid_ff, fin_valid_in;
   logic                  fin_found_ff;
   logic [ADDR_W-1:0]     fin_addr_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_found_ff;
   logic [ADDR_W-1:0]     rsp_addr_ff;

   logic                  req_load, s1_go, fin_go, fin_free, rsp_load;
   logic                  match;
   logic                  take_hit;
   logic [ADDR_W-1:0]     match_start;
   logic [ADDR_W-1:0]     offset_sext;
   pattern_cfg_type       pcfg;

   // configuration write decode
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < PAT_WORDS; w++) pat_word_ff[w] <= '0;
         care_ff      <= '0;
         length_ff    <= '0;
         offset_ff    <= '0;
         backwards_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_PAT_0_7:   pat_word_ff[0] <= csr_wdata;
            CSR_PAT_8_15:  pat_word_ff[1] <= csr_wdata;
            CSR_PAT_16_23: pat_word_ff[2] <= csr_wdata;
            CSR_PAT_24_31: pat_word_ff[3] <= csr_wdata;
            CSR_CARE_MASK: care_ff        <= csr_wdata[CARE_W-1:0];
            CSR_LENGTH:    length_ff      <= csr_wdata[LEN_W-1:0];
            CSR_OFFSET:    offset_ff      <= csr_wdata[OFFSET_W-1:0];
            CSR_BACKWARDS: backwards_ff   <= csr_wdata[0];
         endcase
      end
   end

   // stage handshakes: only a last byte needs room downstream
   always_comb begin
      rsp_load   = !rsp_valid_ff || rsp_tready;
      fin_go     = fin_valid_ff && rsp_load;
      fin_free   = !fin_valid_ff || fin_go;
      s1_go      = s1_valid_ff && (!s1_last_ff || fin_free);
      req_tready = !s1_valid_ff || s1_go;
      req_load   = req_tvalid && req_tready;
   end

   // window shift and range byte count
   always_comb begin
      window_in        = window_ff << BYTE_W;
      window_in[BYTE_W-1:0] = req_tdata[BYTE_W-1:0];
      if (start_ff)
         seen_in = SEEN_W'(1);
      else if (seen_ff == SEEN_W'(MAX_PATTERN_BYTES))
         seen_in = seen_ff;
      else
         seen_in = seen_ff + SEEN_W'(1);
      if (req_load)
         s1_valid_in = 1'b1;
      else if (s1_go)
         s1_valid_in = 1'b0;
      else
         s1_valid_in = s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         seen_ff     <= '0;
         start_ff    <= 1'b1;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_load) begin
            seen_ff  <= seen_in;
            start_ff <= req_tlast;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         window_ff  <= window_in;
         s1_addr_ff <= req_tdata[BYTE_W +: ADDR_W];
         s1_last_ff <= req_tlast;
      end
   end

   // masked compare of the window
   always_comb begin
      pcfg.pattern = {pat_word_ff[3], pat_word_ff[2], pat_word_ff[1], pat_word_ff[0]};
      pcfg.care    = care_ff;
      pcfg.length  = length_ff;
   end

   mbps_match #(
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_match (
      .cfg    (pcfg),
      .window (window_ff),
      .seen   (seen_ff),
      .match  (match)
   );

   // hit tracking: first hit going forward, every hit going backward
   always_comb begin
      match_start = s1_addr_ff - (ADDR_W'(length_ff) - ADDR_W'(1));
      take_hit    = match && (backwards_ff || !hit_seen_ff);
      hit_seen_in = hit_seen_ff || take_hit;
      hit_addr_in = take_hit ? match_start : hit_addr_ff;
      if (s1_go && s1_last_ff)
         fin_valid_in = 1'b1;
      else if (fin_go)
         fin_valid_in = 1'b0;
      else
         fin_valid_in = fin_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_seen_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
         if (s1_go)
            hit_seen_ff <= hit_seen_in && !s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         hit_addr_ff <= hit_addr_in;
         if (s1_last_ff) begin
            fin_found_ff <= hit_seen_in;
            fin_addr_ff  <= hit_addr_in;
         end
      end
   end

   // result register: apply the signed offset
   assign offset_sext = {{(ADDR_W-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fin_go) begin
         rsp_found_ff <= fin_found_ff;
         rsp_addr_ff  <= fin_found_ff ? (fin_addr_ff + offset_sext) : '0;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_addr_ff;
   assign rsp_tuser[0] = rsp_found_ff;

endmodule

// ===== rtl/mbps_match.sv =====
// ----------------------------------------------------------------------------
// mbps_match - masked compare of the byte window against the pattern
// Lines the newest length bytes of the window up with pattern bytes 0 to
// length-1 (oldest byte against byte 0) and checks every byte with its
// care bit set. Purely combinational; sits behind the window register.
// ----------------------------------------------------------------------------
module mbps_match #(
   parameter int MAX_PATTERN_BYTES = 32
) (
   input  mbps_pkg::pattern_cfg_type                cfg,
   input  logic [MAX_PATTERN_BYTES*8-1:0]           window,   // newest byte lowest
   input  logic [$clog2(MAX_PATTERN_BYTES+1)-1:0]   seen,
   output logic                                     match
);
   import mbps_pkg::*;

   localparam int SEEN_W = $clog2(MAX_PATTERN_BYTES + 1);
   localparam int CMP_W  = ((SEEN_W > LEN_W) ? SEEN_W : LEN_W) + 1;
   localparam int IDX_W  = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
   localparam int N_CFG  = (MAX_PATTERN_BYTES < PAT_BYTES) ? MAX_PATTERN_BYTES : PAT_BYTES;

   logic [BYTE_W-1:0]            pat_arr [MAX_PATTERN_BYTES];
   logic [MAX_PATTERN_BYTES-1:0] care_vec;
   logic [MAX_PATTERN_BYTES-1:0] byte_ok;
   logic [CMP_W-1:0]             len_c;
   logic [CMP_W-1:0]             seen_c;
   logic [CMP_W-1:0]             diff;
   logic [IDX_W-1:0]             idx;
   logic                         len_ok;

   // pattern bytes beyond the configured ones are zero and don't care
   always_comb begin
      for (int k = 0; k < MAX_PATTERN_BYTES; k++) begin
         pat_arr[k]  = '0;
         care_vec[k] = 1'b0;
      end
      for (int k = 0; k < N_CFG; k++) begin
         pat_arr[k]  = cfg.pattern[k*BYTE_W +: BYTE_W];
         care_vec[k] = cfg.care[k];
      end
   end

   // window byte j (age j) pairs with pattern byte length-1-j
   always_comb begin
      len_c  = CMP_W'(cfg.length);
      seen_c = CMP_W'(seen);
      len_ok = (cfg.length != '0) && (len_c <= CMP_W'(MAX_PATTERN_BYTES)) &&
               (seen_c >= len_c);
      for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
         diff = len_c - CMP_W'(j) - CMP_W'(1);
         idx  = diff[IDX_W-1:0];
         byte_ok[j] = (CMP_W'(j) >= len_c) || !care_vec[idx] ||
                      (window[j*BYTE_W +: BYTE_W] == pat_arr[idx]);
      end
      match = len_ok && (&byte_ok);
   end

endmodule

// ===== test/masked_byte_pattern_scanner_tb.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_tb - self-checking bench for the pattern scanner
// Streams address ranges of bytes into the scanner. A shadow copy of the
// window, hit tracking and pattern settings predicts one result per range.
// The bench checks each result beat in order, under random idling on both
// sides and with one long stretch at full rate.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
   import mbps_pkg::*;

   localparam int          WIN_BYTES   = 32;
   localparam int          MAX_RANGE   = 64;
   localparam int          PEND_DEPTH  = 64;
   localparam int unsigned CYCLE_LIMIT = 500000;

   typedef struct packed {
      logic        found;
      logic [63:0] addr;
   } scan_result_type;

   // DUT ports
   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;   // data_byte, byte_address
   logic                   req_tlast;   // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;   // match_address
   logic [0:0]             rsp_tuser;   // found

   // shadow copy of the pattern settings
   logic [63:0] pat_word [PAT_WORDS];
   logic [31:0] care_bits;
   logic [5:0]  pat_len;
   logic [31:0] res_offset;
   logic        backwards;

   // shadow copy of the scan state
   logic [7:0]  win [WIN_BYTES];
   int unsigned seen_cnt;
   logic        hit_valid;
   logic [63:0] hit_start;

   // expected results, in order
   scan_result_type pending_results [PEND_DEPTH];
   int unsigned     pend_wr;
   int unsigned     pend_rd;

   bit          steady_flow;
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned bytes_sent;
   int unsigned ranges_sent;
   int unsigned results_checked;
   int unsigned matches_checked;

   masked_byte_pattern_scanner DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // result side back-pressure: rsp_tready drops at random, with a chance of about 24 in a hundred
   always @(posedge clock) begin
      rsp_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 24);
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   function automatic logic [7:0] pattern_byte(input int unsigned i);
      return pat_word[i >> 3][(i & 7) * 8 +: 8];
   endfunction

   function automatic void clear_scan();
      for (int i = 0; i < WIN_BYTES; i++) win[i] = 8'h00;
      seen_cnt  = 0;
      hit_valid = 1'b0;
      hit_start = '0;
   endfunction

   // newest len bytes against the pattern, oldest byte is pattern byte 0
   function automatic bit window_hit(input int unsigned len);
      for (int i = 0; i < len; i++) begin
         if (care_bits[i] && win[len - 1 - i] != pattern_byte(i)) return 1'b0;
      end
      return 1'b1;
   endfunction

   // shifts one byte in; returns 1 when the byte closes a range
   function automatic bit scan_predict(input logic [7:0] data, input logic [63:0] addr,
                                       input logic last, output scan_result_type res);
      int unsigned len;
      len = pat_len;
      for (int i = WIN_BYTES - 1; i > 0; i--) win[i] = win[i - 1];
      win[0] = data;
      if (seen_cnt < WIN_BYTES) seen_cnt++;
      if (len != 0 && len <= WIN_BYTES && seen_cnt >= len && window_hit(len)) begin
         if (backwards || !hit_valid) begin
            hit_valid = 1'b1;
            hit_start = addr - 64'(len - 1);
         end
      end
      res = '0;
      if (!last) return 1'b0;
      if (hit_valid) begin
         res.found = 1'b1;
         res.addr  = hit_start + {{32{res_offset[31]}}, res_offset};
      end
      clear_scan();
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pend_wr == pend_rd) begin
            $error("result beat with nothing pending: found=%0d match_address=%h",
                   rsp_tuser[0], rsp_tdata);
            error_count++;
         end else begin
            want = pending_results[pend_rd % PEND_DEPTH];
            pend_rd++;
            results_checked++;
            if (want.found) matches_checked++;
            if (rsp_tuser[0] !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_tuser[0]);
               error_count++;
            end
            if (rsp_tdata !== want.addr) begin
               $error("match_address: expected %h, got %h", want.addr, rsp_tdata);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   // one byte beat; called and returns at a rising edge
   task automatic send_byte(input logic [7:0] data, input logic [63:0] addr,
                            input logic last);
      scan_result_type res;
      while (!steady_flow && $urandom_range(99) < 24) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {addr, data};
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (scan_predict(data, addr, last, res)) begin
         pending_results[pend_wr % PEND_DEPTH] = res;
         pend_wr++;
         ranges_sent++;
      end
   endtask

   // wait for the pipeline to empty before touching the registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_PAT_0_7:   pat_word[0] = value;
         CSR_PAT_8_15:  pat_word[1] = value;
         CSR_PAT_16_23: pat_word[2] = value;
         CSR_PAT_24_31: pat_word[3] = value;
         CSR_CARE_MASK: care_bits   = value[31:0];
         CSR_LENGTH:    pat_len     = value[5:0];
         CSR_OFFSET:    res_offset  = value[31:0];
         CSR_BACKWARDS: backwards   = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // full register set, written while idle
   task automatic load_settings(input logic [63:0] p0, input logic [63:0] p1,
                                input logic [63:0] p2, input logic [63:0] p3,
                                input logic [31:0] care, input logic [5:0] len,
                                input logic [31:0] offset, input logic back);
      wait_idle();
      write_reg(CSR_PAT_0_7, p0);
      write_reg(CSR_PAT_8_15, p1);
      write_reg(CSR_PAT_16_23, p2);
      write_reg(CSR_PAT_24_31, p3);
      write_reg(CSR_CARE_MASK, {32'h0, care});
      write_reg(CSR_LENGTH, {58'h0, len});
      write_reg(CSR_OFFSET, {32'h0, offset});
      write_reg(CSR_BACKWARDS, {63'h0, back});
      csr_we <= 1'b0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_settings();
      int unsigned r;
      logic [31:0] care;
      logic [5:0]  len;
      logic [31:0] offset;
      r = $urandom_range(99);
      if (r < 10)      care = 32'h0;
      else if (r < 20) care = 32'hFFFF_FFFF;
      else             care = $urandom | $urandom;
      r = $urandom_range(99);
      if (r < 8)       len = 6'd0;
      else if (r < 18) len = 6'd32;
      else if (r < 26) len = 6'($urandom_range(33, 63));
      else if (r < 34) len = 6'($urandom_range(13, 31));
      else             len = 6'($urandom_range(1, 12));
      case ($urandom_range(7))
         0:       offset = 32'h8000_0000;
         1:       offset = 32'h7FFF_FFFF;
         2:       offset = 32'h0;
         3:       offset = 32'hFFFF_FFFF;
         default: offset = $urandom;
      endcase
      load_settings(rand64(), rand64(), rand64(), rand64(), care, len, offset,
                    1'($urandom_range(1)));
   endtask

   // one range, mostly with planted copies of the pattern
   task automatic send_random_range();
      logic [7:0]  range_data [MAX_RANGE];
      logic [63:0] base;
      logic [63:0] addr;
      int unsigned n;
      int unsigned len;
      int unsigned pos;
      bit          scattered;
      len = pat_len;
      case ($urandom_range(9))
         0:       n = $urandom_range(1, 3);
         1:       n = $urandom_range(32, MAX_RANGE);
         default: n = $urandom_range(4, 40);
      endcase
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 30) range_data[i] = pattern_byte($urandom_range(31));
         else                         range_data[i] = 8'($urandom);
      end
      if (len != 0 && len <= WIN_BYTES && len <= n && $urandom_range(99) < 80) begin
         repeat ($urandom_range(1, 3)) begin
            pos = $urandom_range(0, n - len);
            for (int j = 0; j < len; j++)
               range_data[pos + j] = care_bits[j] ? pattern_byte(j) : 8'($urandom);
            // near miss: break one byte of the copy
            if ($urandom_range(99) < 15)
               range_data[pos + $urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
         end
      end
      case ($urandom_range(9))
         0, 1, 2: base = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 70));
         3, 4, 5: base = 64'($urandom_range(0, 70));
         default: base = rand64();
      endcase
      scattered = ($urandom_range(99) < 5);
      for (int i = 0; i < n; i++) begin
         addr = base + 64'(i);
         if (scattered && $urandom_range(9) == 0) addr = rand64();
         send_byte(range_data[i], addr, i == n - 1);
      end
   endtask

   task automatic run_random_phases(input int unsigned budget);
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         random_settings();
         repeat ($urandom_range(3, 8)) send_random_range();
      end
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // registers at reset value: length zero never matches
   task automatic test_reset_state();
      send_byte(8'h00, 64'h0, 1'b0);
      send_byte(8'hFF, 64'h1, 1'b1);
   endtask

   // one-byte pattern, both directions, offset extremes, address wrap
   task automatic test_direction_and_offset();
      load_settings(64'hFF, 64'h0, 64'h0, 64'h0, 32'hFFFF_FFFF, 6'd1,
                    32'h7FFF_FFFF, 1'b0);
      send_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      send_byte(8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_byte(8'hFF, 64'h0, 1'b1);
      load_settings(64'hFF, 64'h0, 64'h0, 64'h0, 32'hFFFF_FFFF, 6'd1,
                    32'h8000_0000, 1'b1);
      send_byte(8'hFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      send_byte(8'h00, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
      send_byte(8'hFF, 64'h0, 1'b1);
   endtask

   // range shorter than the pattern, all wildcards, over-long lengths
   task automatic test_pattern_lengths();
      load_settings(64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 6'd3, 32'h0, 1'b0);
      send_byte(8'h12, 64'h40, 1'b0);
      send_byte(8'h34, 64'h41, 1'b1);
      send_byte(8'h56, 64'hFFFF_FFFF_FFFF_FFFD, 1'b0);
      send_byte(8'h78, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
      send_byte(8'h9A, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      load_settings(64'h0, 64'h0, 64'h0, 64'h0, 32'h0, 6'd33, 32'h0, 1'b0);
      send_byte(8'h01, 64'h10, 1'b0);
      send_byte(8'h02, 64'h11, 1'b0);
      send_byte(8'h03, 64'h12, 1'b1);
      load_settings(64'h0, 64'h0, 64'h0, 64'h0, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF,
                    1'b1);
      send_byte(8'h00, 64'h20, 1'b0);
      send_byte(8'h00, 64'h21, 1'b1);
   endtask

   // addresses are not required to be consecutive
   task automatic test_unordered_addresses();
      load_settings(64'hA55A, 64'h0, 64'h0, 64'h0, 32'h3, 6'd2, 32'h0, 1'b0);
      send_byte(8'h5A, 64'h100, 1'b0);
      send_byte(8'hA5, 64'h7, 1'b1);
   endtask

   task automatic test_random_scans();
      steady_flow = 1'b0;
      run_random_phases(1400);
   endtask

   task automatic test_back_to_back_scans();
      steady_flow = 1'b1;
      run_random_phases(260);
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------
   initial begin
      clock           = 1'b0;
      steady_flow     = 1'b0;
      error_count     = 0;
      cycle_count     = 0;
      bytes_sent      = 0;
      ranges_sent     = 0;
      results_checked = 0;
      matches_checked = 0;
      pend_wr         = 0;
      pend_rd         = 0;
      for (int i = 0; i < PAT_WORDS; i++) pat_word[i] = '0;
      care_bits  = '0;
      pat_len    = '0;
      res_offset = '0;
      backwards  = 1'b0;
      clear_scan();
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_PAT_0_7;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      rsp_tready <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_direction_and_offset();
      test_pattern_lengths();
      test_unordered_addresses();
      test_random_scans();
      test_back_to_back_scans();

      // drain, then allow the result pipeline to settle
      req_tvalid <= 1'b0;
      while (pend_wr != pend_rd) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Scanned %0d bytes in %0d ranges; %0d results checked, %0d with a match.",
               bytes_sent, ranges_sent, results_checked, matches_checked);
      $display("Covered both directions, lengths 0 to 63, address wrap and offset limits.");
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
